@@ hdl/mbpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Blink pattern generator package
// Shared constants, request and register codes, and queue word types.
// ----------------------------------------------------------------------------
package mbpg_pkg;

  // Number of channels held by the block.
  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  // Channels that appear in the result fields.
  localparam int VIS_CH   = (CHANNELS < 8) ? CHANNELS : 8;

  // Pattern field widths.
  localparam int MASK_W   = 32;
  localparam int LEN_W    = 6;
  localparam int POS_W    = 5;
  localparam int HOLD_W   = 16;
  localparam int MAX_LEN  = 32;

  // Port widths.
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Queue between front end and engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request codes carried on the input user field.
  typedef enum logic [IN_USER_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_SWITCH = 3'd1,
    REQ_SET    = 3'd2,
    REQ_ON     = 3'd3,
    REQ_OFF    = 3'd4,
    REQ_LOAD   = 3'd5
  } req_t;

  // Operations as classified by the front end.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SWITCH,
    OP_SET,
    OP_ON,
    OP_OFF,
    OP_LOAD,
    OP_NONE
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT   = 2'd0,
    CFG_CHANNELS = 2'd1
  } cfg_reg_t;

  // One classified word in the queue.
  typedef struct packed {
    op_t                op;
    logic [CH_W-1:0]    ch;
    logic               turn_on;
    logic [MASK_W-1:0]  bits;
    logic [LEN_W-1:0]   len;
    logic [HOLD_W-1:0]  hold;
  } qword_t;

  // Configuration seen by the engine.
  typedef struct packed {
    logic       invert;
    logic [3:0] chan_cnt;
  } cfg_t;

  // Engine status.
  typedef struct packed {
    logic busy;
    logic ticking;
  } sts_t;

endpackage

@@ hdl/mbpg_front.sv @@
// ----------------------------------------------------------------------------
// Blink pattern generator front end
// Accepts input words, decodes the request, clamps the channel and length.
// ----------------------------------------------------------------------------
module mbpg_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // channel[7:0], turn_on[8], pattern_bits[40:9], pattern_length[46:41],
  // step_ms[62:47], zero pad[63]
  input  logic [mbpg_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type[2:0]
  input  logic [mbpg_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            q_push,
  output mbpg_pkg::qword_t                q_din,
  input  logic                            q_full
);

  logic [7:0]                   ch_raw;
  logic [mbpg_pkg::LEN_W-1:0]   len_raw;

  assign ch_raw  = s_tdata[7:0];
  assign len_raw = s_tdata[46:41];

  // The queue alone decides when a word can be taken.
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Decode and clamp the incoming word.
  always_comb begin
    unique case (s_tuser)
      mbpg_pkg::REQ_TICK:   q_din.op = mbpg_pkg::OP_TICK;
      mbpg_pkg::REQ_SWITCH: q_din.op = mbpg_pkg::OP_SWITCH;
      mbpg_pkg::REQ_SET:    q_din.op = mbpg_pkg::OP_SET;
      mbpg_pkg::REQ_ON:     q_din.op = mbpg_pkg::OP_ON;
      mbpg_pkg::REQ_OFF:    q_din.op = mbpg_pkg::OP_OFF;
      mbpg_pkg::REQ_LOAD:   q_din.op = mbpg_pkg::OP_LOAD;
      default:              q_din.op = mbpg_pkg::OP_NONE;
    endcase

    // Channels past the last one go to the last one.
    if (ch_raw > 8'(mbpg_pkg::CHANNELS - 1)) begin
      q_din.ch = mbpg_pkg::CH_W'(mbpg_pkg::CHANNELS - 1);
    end else begin
      q_din.ch = mbpg_pkg::CH_W'(ch_raw);
    end

    // Lengths above a full mask saturate.
    if (len_raw > mbpg_pkg::LEN_W'(mbpg_pkg::MAX_LEN)) begin
      q_din.len = mbpg_pkg::LEN_W'(mbpg_pkg::MAX_LEN);
    end else begin
      q_din.len = len_raw;
    end

    q_din.turn_on = s_tdata[8];
    q_din.bits    = s_tdata[40:9];
    q_din.hold    = s_tdata[62:47];
  end

endmodule

@@ hdl/mbpg_queue.sv @@
// ----------------------------------------------------------------------------
// Blink pattern generator queue
// Small FIFO that decouples the front end from the channel engine.
// ----------------------------------------------------------------------------
module mbpg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mbpg_pkg::qword_t  din,
  output logic              full,
  input  logic              pop,
  output mbpg_pkg::qword_t  dout,
  output logic              valid
);

  mbpg_pkg::qword_t                 store [mbpg_pkg::QDEPTH];
  logic [mbpg_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mbpg_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mbpg_pkg::QCNT_W-1:0]      fill;

  assign full  = (fill == mbpg_pkg::QCNT_W'(mbpg_pkg::QDEPTH));
  assign valid = (fill != '0);
  assign dout  = store[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mbpg_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mbpg_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + mbpg_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - mbpg_pkg::QCNT_W'(1);
      end
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end

endmodule

@@ hdl/mbpg_engine.sv @@
// ----------------------------------------------------------------------------
// Blink pattern generator engine
// Holds the channel state, runs commands and sweeps channels on ticks.
// ----------------------------------------------------------------------------
module mbpg_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  mbpg_pkg::cfg_t                   cfg,
  input  logic                             q_valid,
  input  mbpg_pkg::qword_t                 q_word,
  output logic                             q_pop,
  output mbpg_pkg::sts_t                   sts,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pin_levels[7:0], on_flags[15:8]
  output logic [mbpg_pkg::OUT_DATA_W-1:0]  m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_RESULT
  } state_t;

  state_t                           state;
  logic [mbpg_pkg::CNT_W-1:0]       idx;
  logic [mbpg_pkg::CNT_W-1:0]       cnt;
  logic [mbpg_pkg::CNT_W-1:0]       eff_cnt;
  logic [mbpg_pkg::CH_W-1:0]        t;

  logic [mbpg_pkg::MASK_W-1:0]      mask_store   [mbpg_pkg::CHANNELS];
  logic [mbpg_pkg::LEN_W-1:0]       length_store [mbpg_pkg::CHANNELS];
  logic [mbpg_pkg::HOLD_W-1:0]      hold_store   [mbpg_pkg::CHANNELS];
  logic [mbpg_pkg::POS_W-1:0]       bit_position [mbpg_pkg::CHANNELS];
  logic [mbpg_pkg::HOLD_W-1:0]      wait_count   [mbpg_pkg::CHANNELS];
  logic [mbpg_pkg::CHANNELS-1:0]    channel_on;
  logic [mbpg_pkg::CHANNELS-1:0]    level_out;

  logic [mbpg_pkg::HOLD_W-1:0]      wait_dec;
  logic [mbpg_pkg::LEN_W-1:0]       pos_inc;
  logic [mbpg_pkg::POS_W-1:0]       pos_next;
  logic                             pat_bit;

  assign q_pop       = (state == S_IDLE) && q_valid;
  assign sts.busy    = (state != S_IDLE);
  assign sts.ticking = (state == S_TICK);
  assign t           = idx[mbpg_pkg::CH_W-1:0];

  // Enabled channel count, limited to the channels present.
  always_comb begin
    if (int'(cfg.chan_cnt) > mbpg_pkg::CHANNELS) begin
      eff_cnt = mbpg_pkg::CNT_W'(mbpg_pkg::CHANNELS);
    end else begin
      eff_cnt = mbpg_pkg::CNT_W'(cfg.chan_cnt);
    end
  end

  // Per-channel tick arithmetic for the channel under the sweep index.
  always_comb begin
    wait_dec = (wait_count[t] != '0) ? wait_count[t] - mbpg_pkg::HOLD_W'(1) : '0;
    pat_bit  = mask_store[t][bit_position[t]];
    pos_inc  = mbpg_pkg::LEN_W'(bit_position[t]) + mbpg_pkg::LEN_W'(1);
    if (pos_inc >= length_store[t]) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[mbpg_pkg::POS_W-1:0];
    end
  end

  // Sequencer, channel state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
      channel_on <= '0;
      level_out  <= '0;
      for (int i = 0; i < mbpg_pkg::CHANNELS; i++) begin
        mask_store[i]   <= '0;
        length_store[i] <= '0;
        hold_store[i]   <= '0;
        bit_position[i] <= '0;
        wait_count[i]   <= '0;
      end
    end else begin
      // The result state reloads the register itself when the word leaves.
      if (m_tvalid && m_tready && (state != S_RESULT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_RESULT;
            unique case (q_word.op)
              mbpg_pkg::OP_TICK: begin
                idx <= '0;
                cnt <= eff_cnt;
                if (eff_cnt != '0) begin
                  state <= S_TICK;
                end
              end
              mbpg_pkg::OP_SWITCH: begin
                channel_on[q_word.ch]   <= !channel_on[q_word.ch];
                bit_position[q_word.ch] <= '0;
              end
              mbpg_pkg::OP_SET: begin
                channel_on[q_word.ch]   <= q_word.turn_on;
                bit_position[q_word.ch] <= '0;
              end
              mbpg_pkg::OP_ON: begin
                channel_on[q_word.ch]   <= 1'b1;
                bit_position[q_word.ch] <= '0;
              end
              mbpg_pkg::OP_OFF: begin
                channel_on[q_word.ch] <= 1'b0;
              end
              mbpg_pkg::OP_LOAD: begin
                channel_on[q_word.ch]   <= q_word.turn_on;
                mask_store[q_word.ch]   <= q_word.bits;
                length_store[q_word.ch] <= q_word.len;
                hold_store[q_word.ch]   <= q_word.hold;
                bit_position[q_word.ch] <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        S_TICK: begin
          // One channel per cycle: count down, then step or idle.
          if (wait_dec != '0) begin
            wait_count[t] <= wait_dec;
          end else if (!channel_on[t]) begin
            wait_count[t] <= '0;
            level_out[t]  <= cfg.invert;
          end else begin
            level_out[t]    <= pat_bit ^ cfg.invert;
            bit_position[t] <= pos_next;
            wait_count[t]   <= hold_store[t];
          end
          if (idx + mbpg_pkg::CNT_W'(1) == cnt) begin
            state <= S_RESULT;
          end else begin
            idx <= idx + mbpg_pkg::CNT_W'(1);
          end
        end

        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {8'(channel_on[mbpg_pkg::VIS_CH-1:0]),
                         8'(level_out[mbpg_pkg::VIS_CH-1:0])};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/multichannel_blink_pattern_generator_core.sv @@
// ----------------------------------------------------------------------------
// Multichannel blink pattern generator
// Per-channel blink masks driven by millisecond tick words.
// ----------------------------------------------------------------------------
// Every input word yields exactly one output word carrying the pin levels and
// on flags of channels 0 to 7 after the word's update. A command word
// (switch, set, on, off, set data) is applied by the engine and then
// registered as its result; a tick word sweeps the enabled channels one
// per cycle through the channel engine before its result is registered.
// A two-word queue sits between the input decoder and the engine, and
// the result register lets the engine finish while the consumer stalls.
// Write configuration only while no word is in flight.
module multichannel_blink_pattern_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // channel[7:0], turn_on[8], pattern_bits[40:9], pattern_length[46:41],
  // step_ms[62:47], zero pad[63]
  input  logic [mbpg_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type[2:0]
  input  logic [mbpg_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pin_levels[7:0], on_flags[15:8]
  output logic [mbpg_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbpg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mbpg_pkg::cfg_t    cfg;
  mbpg_pkg::qword_t  q_din;
  mbpg_pkg::qword_t  q_word;
  mbpg_pkg::sts_t    eng_sts;
  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert   <= 1'b0;
      cfg.chan_cnt <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mbpg_pkg::CFG_INVERT:   cfg.invert   <= cfg_data[0];
        mbpg_pkg::CFG_CHANNELS: cfg.chan_cnt <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mbpg_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (q_push),
    .q_din    (q_din),
    .q_full   (q_full)
  );

  mbpg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_word),
    .valid (q_valid)
  );

  mbpg_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .sts      (eng_sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The engine only takes a word that is present.
  a_pop_has_word: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  // No new word is taken during a channel sweep.
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    eng_sts.ticking |-> !q_pop)
    else $error("queue popped during a tick sweep");

  // A fresh result follows a cycle in which the engine was working.
  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> $past(eng_sts.busy))
    else $error("result appeared without engine activity");

endmodule
